FILE: rtl/core/dcfft_pkg.sv
// ----------------------------------------------------------------------------
// dcfft_pkg
// Shared types, constants and arithmetic for the dual-channel radix-2 FFT.
// ----------------------------------------------------------------------------
package dcfft_pkg;

    localparam int POINTS  = 128;
    localparam int LOG_PTS = $clog2(POINTS);
    localparam int HALF    = POINTS / 2;
    localparam int IN_W    = 16;
    localparam int DAT_W   = 24;
    localparam int TW_W    = 17;
    localparam int PRD_W   = DAT_W + TW_W + 1;
    localparam int CNT_W   = LOG_PTS + 1;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    typedef enum logic {
        ST_LOAD,
        ST_XFORM
    } t_state;

    typedef struct packed {
        logic signed [DAT_W-1:0] re;
        logic signed [DAT_W-1:0] im;
    } t_cpx;

    typedef struct packed {
        t_cpx a;
        t_cpx b;
    } t_cpx2;

    typedef logic signed [TW_W-1:0] t_tw;
    typedef t_tw t_tw_tab [0:HALF-1];

    // restoring long division, unsigned 64-bit
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tw sine_q15(int k);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        x   = (PI_Q30 * 64'd2 * longint'(k)) / POINTS;
        t   = x;
        sum = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = udiv(t, longint'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        return TW_W'((sum + 16384) >>> 15);
    endfunction

    function automatic t_tw_tab build_tw(logic imag);
        t_tw_tab tab;
        int      q;
        q = POINTS / 4;
        for (int m = 0; m < HALF; m++) begin
            if (m <= q) begin
                tab[m] = imag ? -sine_q15(m) : sine_q15(q - m);
            end else begin
                tab[m] = imag ? -sine_q15(HALF - m) : -sine_q15(m - q);
            end
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_RE = build_tw(1'b0);
    localparam t_tw_tab TW_IM = build_tw(1'b1);

    function automatic logic [LOG_PTS-1:0] bit_rev(logic [LOG_PTS-1:0] i);
        logic [LOG_PTS-1:0] r;
        for (int b = 0; b < LOG_PTS; b++) begin
            r[LOG_PTS-1-b] = i[b];
        end
        return r;
    endfunction

    function automatic t_cpx cmul(t_cpx x, t_tw wr, t_tw wi);
        logic signed [PRD_W-2:0] m1;
        logic signed [PRD_W-2:0] m2;
        logic signed [PRD_W-2:0] m3;
        logic signed [PRD_W-2:0] m4;
        logic signed [PRD_W-1:0] pr;
        logic signed [PRD_W-1:0] pi;
        t_cpx                    r;
        m1   = x.re * wr;
        m2   = x.im * wi;
        m3   = x.re * wi;
        m4   = x.im * wr;
        pr   = PRD_W'(m1) - PRD_W'(m2) + PRD_W'(16384);
        pi   = PRD_W'(m3) + PRD_W'(m4) + PRD_W'(16384);
        r.re = DAT_W'(pr >>> 15);
        r.im = DAT_W'(pi >>> 15);
        return r;
    endfunction

endpackage

FILE: rtl/core/dcfft_cell.sv
// ----------------------------------------------------------------------------
// dcfft_cell
// One radix-2 DIT butterfly stage with a feedback delay line, both channels.
// ----------------------------------------------------------------------------
module dcfft_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [2:0]                   i_stage,
    input  logic                         i_val,
    input  dcfft_pkg::t_cpx2             i_data,
    output logic                         o_val,
    output dcfft_pkg::t_cpx2             o_data
);
    import dcfft_pkg::*;

    t_cpx2                r_dly [0:HALF-1];
    logic                 r_run;
    logic [CNT_W:0]       r_pos;
    logic                 r_val;
    t_cpx2                r_data;

    logic [CNT_W:0]       h;
    logic [CNT_W:0]       k;
    logic                 active;
    logic                 ph_b;
    logic [LOG_PTS-2:0]   tw_idx;
    t_cpx2                head;
    t_cpx2                tw_x;
    t_cpx2                push;
    t_cpx2                n_data;

    always_comb begin
        h      = (CNT_W+1)'(1) << i_stage;
        active = r_run || i_val;
        k      = r_run ? r_pos : '0;
        head   = r_dly[(LOG_PTS-1)'(h - 1'b1)];
        ph_b   = (k < (CNT_W+1)'(POINTS)) && ((k & h) != '0);
        tw_idx = (LOG_PTS-1)'((k[LOG_PTS-2:0] & (LOG_PTS-1)'(h - 1'b1))
                 << (3'(LOG_PTS - 1) - i_stage));
        if (tw_idx == '0) begin
            tw_x = i_data;
        end else begin
            tw_x.a = cmul(i_data.a, TW_RE[tw_idx], TW_IM[tw_idx]);
            tw_x.b = cmul(i_data.b, TW_RE[tw_idx], TW_IM[tw_idx]);
        end
        if (ph_b) begin
            push.a.re   = head.a.re - tw_x.a.re;
            push.a.im   = head.a.im - tw_x.a.im;
            push.b.re   = head.b.re - tw_x.b.re;
            push.b.im   = head.b.im - tw_x.b.im;
            n_data.a.re = head.a.re + tw_x.a.re;
            n_data.a.im = head.a.im + tw_x.a.im;
            n_data.b.re = head.b.re + tw_x.b.re;
            n_data.b.im = head.b.im + tw_x.b.im;
        end else begin
            push   = i_data;
            n_data = head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_dly[0] <= push;
            for (int i = 1; i < HALF; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pos <= '0;
            r_val <= 1'b0;
        end else begin
            r_val <= active && (k >= h);
            if (active) begin
                r_pos <= k + 1'b1;
                r_run <= (k + 1'b1) < ((CNT_W+1)'(POINTS) + h);
            end
        end
    end

    assign o_val  = r_val;
    assign o_data = r_data;

    a_out_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val |-> $past(active))
        else $error("cell output without activity");
    a_run_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_pos != '0))
        else $error("running cell at position zero");
    a_ph_b_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (active && ph_b) |-> (r_run || i_val))
        else $error("butterfly without input");

endmodule

FILE: rtl/core/dual_channel_radix2_fft_top.sv
// ----------------------------------------------------------------------------
// dual_channel_radix2_fft_top
// Streaming 128-point dual-channel radix-2 DIT FFT, one frame of latency.
// ----------------------------------------------------------------------------
// Words of the first frame are taken one per cycle; once a frame has been
// transformed, a word is taken only after the bin for the previous word has
// left the holding register, each word returning the matching bin of the
// previous frame through a holding register and the output register, so a
// stalled output blocks the input only when both are full. After the last
// word of a frame the input stalls while the frame is read in bit-reversed
// order through a chain of seven butterfly cells (one per stage, delay-line
// depths 1..64) into the result memory.
module dual_channel_radix2_fft_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [dcfft_pkg::IN_W-1:0]   i_chan_a_real,
    input  logic signed [dcfft_pkg::IN_W-1:0]   i_chan_a_imag,
    input  logic signed [dcfft_pkg::IN_W-1:0]   i_chan_b_real,
    input  logic signed [dcfft_pkg::IN_W-1:0]   i_chan_b_imag,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dcfft_pkg::DAT_W-1:0]  o_bin_a_real,
    output logic signed [dcfft_pkg::DAT_W-1:0]  o_bin_a_imag,
    output logic signed [dcfft_pkg::DAT_W-1:0]  o_bin_b_real,
    output logic signed [dcfft_pkg::DAT_W-1:0]  o_bin_b_imag,
    output logic [dcfft_pkg::LOG_PTS-1:0]       o_bin_index,
    output logic                                o_frame_end
);
    import dcfft_pkg::*;

    t_cpx2                 r_load [0:POINTS-1];
    t_cpx2                 r_res  [0:POINTS-1];

    t_state                r_state;
    t_state                n_state;
    logic [LOG_PTS-1:0]    r_cnt;
    logic                  r_ready;
    logic                  r_rd_pend;
    t_cpx2                 r_rd_data;
    logic [LOG_PTS-1:0]    r_rd_idx;
    logic                  r_out_valid;
    t_cpx2                 r_out;
    logic [LOG_PTS-1:0]    r_out_idx;
    logic [CNT_W-1:0]      r_xcnt;
    logic [LOG_PTS-1:0]    r_wcnt;
    logic                  r_feed_val;
    t_cpx2                 r_feed;

    logic                  in_acc;
    logic                  out_load;
    logic                  load_done;
    logic                  xform_done;
    t_cpx2                 in_word;
    logic                  c_val  [0:LOG_PTS];
    t_cpx2                 c_data [0:LOG_PTS];

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = r_rd_pend && (!r_out_valid || !i_out_stall);
    assign load_done  = in_acc && (r_cnt == LOG_PTS'(POINTS - 1));
    assign xform_done = c_val[LOG_PTS] && (r_wcnt == LOG_PTS'(POINTS - 1));

    always_comb begin
        in_word.a.re = DAT_W'(i_chan_a_real);
        in_word.a.im = DAT_W'(i_chan_a_imag);
        in_word.b.re = DAT_W'(i_chan_b_real);
        in_word.b.im = DAT_W'(i_chan_b_imag);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (load_done) begin
                    n_state = ST_XFORM;
                end
            end
            ST_XFORM: begin
                if (xform_done) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_stall = !((r_state == ST_LOAD) && !r_rd_pend);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_load[r_cnt] <= in_word;
            r_rd_data     <= r_res[r_cnt];
            r_rd_idx      <= r_cnt;
        end
        if (c_val[LOG_PTS]) begin
            r_res[r_wcnt] <= c_data[LOG_PTS];
        end
        r_feed <= r_load[bit_rev(r_xcnt[LOG_PTS-1:0])];
        if (out_load) begin
            r_out     <= r_rd_data;
            r_out_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_ready     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_xcnt      <= '0;
            r_wcnt      <= '0;
            r_feed_val  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_feed_val <= (r_state == ST_XFORM) && !r_xcnt[LOG_PTS];
            if (in_acc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (in_acc && r_ready) begin
                r_rd_pend <= 1'b1;
            end else if (out_load) begin
                r_rd_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load_done) begin
                r_xcnt <= '0;
                r_wcnt <= '0;
            end else if ((r_state == ST_XFORM) && !r_xcnt[LOG_PTS]) begin
                r_xcnt <= r_xcnt + 1'b1;
            end
            if (c_val[LOG_PTS]) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (xform_done) begin
                r_ready <= 1'b1;
            end
        end
    end

    assign c_val[0]  = r_feed_val;
    assign c_data[0] = r_feed;

    for (genvar s = 0; s < LOG_PTS; s++) begin : g_cell
        dcfft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (3'(s)),
            .i_val   (c_val[s]),
            .i_data  (c_data[s]),
            .o_val   (c_val[s+1]),
            .o_data  (c_data[s+1])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_a_real = r_out.a.re;
    assign o_bin_a_imag = r_out.a.im;
    assign o_bin_b_real = r_out.b.re;
    assign o_bin_b_imag = r_out.b.im;
    assign o_bin_index  = r_out_idx;
    assign o_frame_end  = (r_out_idx == LOG_PTS'(POINTS - 1));

    a_no_accept_xform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XFORM) |-> !in_acc)
        else $error("word accepted during transform");
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && r_out_valid && i_out_stall) |=> r_rd_pend)
        else $error("pending word dropped while output stalled");
    a_ready_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("results flag dropped");
    a_write_xform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_val[LOG_PTS] |-> (r_state == ST_XFORM))
        else $error("result write outside transform");

endmodule
